### sv/sorted_key_list_top_assert.svh
// Assertion macros used by the checker file of the sorted key list.
`ifndef SORTED_KEY_LIST_TOP_ASSERT_SVH
`define SORTED_KEY_LIST_TOP_ASSERT_SVH

// Overlapping implication, disabled while reset is asserted.
`define SKL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication that checks the consequent in the next cycle.
`define SKL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/skl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skl_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH);

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_FIND   = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_REWIND = 3'd4;
    localparam logic [2:0] CMD_NEXT   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_PAST_END  = 3'd4;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### sv/skl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skl_cell
    import skl_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_key       i_key,
    input  wire        i_occ,
    input  wire        i_prev_p,
    input  wire        i_prev_d,
    input  t_key       i_left_key,
    input  t_key       i_right_key,
    output t_key       o_key,
    output logic       o_p,
    output logic       o_d
);

    t_key r_key;
    t_key n_key;
    logic eq;

    // The insert point is the first cell that is empty or holds a key not below the new one.
    assign eq    = i_occ && (i_key == r_key);
    assign o_p   = !i_occ || (i_key <= r_key);
    assign o_d   = i_prev_d || eq;
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins) begin
            if (i_prev_p) begin
                n_key = i_left_key;
            end else if (o_p) begin
                n_key = i_key;
            end
        end else if (i_ctrl.del && o_d) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

`default_nettype wire

### sv/sorted_key_list_top.sv
// Sorted key list: a table of up to 16 unsigned keys held in ascending order.
// An item (i_command, i_key) is taken at a rising edge where start is high
// and busy is low. Commands are insert, delete, find, clear, rewind and next.
// Each item gives exactly one result word on o_value, o_found, o_status and
// o_count, shown for one cycle with o_done high; the receiver cannot stall.
// Timing: busy is high for the cycle after the accepting edge, and the
// result word is shown in the cycle after that. No item is taken while
// busy is high, so the next one can be taken while the result word is
// shown. In the busy cycle every cell compares its key with the item key
// and moves a key to or from a neighbor, then the result registers.
// A next past the last stored key gives status past end and value zero.
// Reset empties the table, rewinds the cursor and drops busy and o_done;
// stored key cells are not cleared, since keys beyond the count are unused.
// o_count holds the number of stored keys after the last finished item.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_list_top
    import skl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_command,
    input  wire  [31:0] i_key,
    output logic        o_done,
    output logic [31:0] o_value,
    output logic        o_found,
    output logic [2:0]  o_status,
    output logic [4:0]  o_count
);

    logic        r_busy;
    logic        n_busy;
    logic [2:0]  r_cmd;
    t_key        r_key;
    t_cnt        r_count;
    t_cnt        n_count;
    t_cnt        r_cursor;
    t_cnt        n_cursor;
    logic        r_done;
    logic [31:0] r_value;
    logic [31:0] n_value;
    logic        r_found;
    logic        n_found;
    logic [2:0]  r_status;
    logic [2:0]  n_status;

    t_cell_ctrl  ctrl;
    t_key        cell_key [DEPTH];
    logic        cell_p   [DEPTH];
    logic        cell_d   [DEPTH];
    logic        full;
    logic        hit;
    logic        accept;

    assign accept = start && !r_busy;
    assign full   = (r_count == t_cnt'(DEPTH));
    assign hit    = cell_d[DEPTH-1];

    assign ctrl.ins = r_busy && (r_cmd == CMD_INSERT) && !full;
    assign ctrl.del = r_busy && (r_cmd == CMD_DELETE);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic occ;
        logic prev_p;
        logic prev_d;
        t_key left_key;
        t_key right_key;

        assign occ = (t_cnt'(i) < r_count);

        if (i == 0) begin : g_first
            assign prev_p   = 1'b0;
            assign prev_d   = 1'b0;
            assign left_key = r_key;
        end else begin : g_mid
            assign prev_p   = cell_p[i-1];
            assign prev_d   = cell_d[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
        end

        skl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_key       (r_key),
            .i_occ       (occ),
            .i_prev_p    (prev_p),
            .i_prev_d    (prev_d),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .o_key       (cell_key[i]),
            .o_p         (cell_p[i]),
            .o_d         (cell_d[i])
        );
    end

    always_comb begin
        n_busy   = r_busy;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_value  = '0;
        n_found  = 1'b0;
        n_status = ST_OK;
        if (accept) begin
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_busy = 1'b0;
            unique case (r_cmd)
                CMD_INSERT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + t_cnt'(1);
                    end
                end
                CMD_DELETE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (hit) begin
                        n_count = r_count - t_cnt'(1);
                        n_found = 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                CMD_FIND: begin
                    if (hit) begin
                        n_found = 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                CMD_REWIND: begin
                    n_cursor = '0;
                end
                CMD_NEXT: begin
                    if (r_cursor < r_count) begin
                        n_value  = 32'(cell_key[r_cursor[IDX_W-1:0]]);
                        n_cursor = r_cursor + t_cnt'(1);
                    end else begin
                        n_status = ST_PAST_END;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_count  <= '0;
            r_cursor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_done   <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= t_key'(i_key);
        end
        if (r_busy) begin
            r_value  <= n_value;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_value  = r_value;
    assign o_found  = r_found;
    assign o_status = r_status;
    assign o_count  = 5'(r_count);

endmodule

`default_nettype wire

### sv/skl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_list_top_assert.svh"

module skl_checker
    import skl_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_done,
    input wire [31:0] o_value,
    input wire        o_found,
    input wire [2:0]  o_status,
    input wire [4:0]  o_count
);

    logic hit_word;

    assign hit_word = o_done && (o_found || (o_value != 32'd0));

    `SKL_ASSERT_IMP(a_result_lat, i_clk, i_rst_n, start && !busy, ##2 o_done, "result word late")
    `SKL_ASSERT_NXT(a_busy_set, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `SKL_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, !busy && $past(busy), "word without busy")
    `SKL_ASSERT_IMP(a_count_max, i_clk, i_rst_n, o_done, o_count <= 5'(DEPTH), "count above depth")
    `SKL_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, hit_word, o_status == ST_OK, "error status on a hit")

endmodule

bind sorted_key_list_top skl_checker u_skl_checker (.*);

`default_nettype wire
